// ===== src/rbmhe_pkg.sv =====
package rbmhe_pkg;

    // Operation codes of an input beat.
    localparam logic [2:0] OP_WEIGHT = 3'd0;
    localparam logic [2:0] OP_BIAS   = 3'd1;
    localparam logic [2:0] OP_INIT   = 3'd2;
    localparam logic [2:0] OP_PROP   = 3'd3;
    localparam logic [2:0] OP_ACCEPT = 3'd4;
    localparam logic [2:0] OP_REJECT = 3'd5;

    // Kind codes of a result beat.
    localparam logic [1:0] KIND_ACT   = 2'd0;
    localparam logic [1:0] KIND_GRAD  = 2'd1;
    localparam logic [1:0] KIND_RATIO = 2'd2;
    localparam logic [1:0] KIND_LAP   = 2'd3;

    // Fixed-point constants (Q16.16).
    localparam logic [31:0] ONE_Q    = 32'h0001_0000;
    localparam logic [31:0] SAT_MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MINV = 32'h8000_0000;
    localparam logic [16:0] LOG2E_Q  = 17'd94548;

    // 2^(-j/16) in Q16 for j = 0..16.
    function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
        logic [16:0] r;
        case (idx)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            5'd16:   r = 17'd32768;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Saturate a wide signed sum to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [63:0] a);
        logic [31:0] r;
        if (a > 64'sh0000_0000_7FFF_FFFF) begin
            r = SAT_MAXV;
        end else if (a < -64'sh0000_0000_8000_0000) begin
            r = SAT_MINV;
        end else begin
            r = a[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/rbmhe_div.sv =====
module rbmhe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    // Restoring divider, one quotient bit per cycle.
    // The upper half of the dividend must be below the divisor.
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_div;
    logic [31:0] r_q;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_lo[31]};
    assign ge    = trial >= {1'b0, r_div};

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_dividend[63:32];
            r_lo  <= i_dividend[31:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_div}) : trial[31:0];
            r_lo  <= {r_lo[30:0], 1'b0};
            r_q   <= {r_q[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== src/rbm_hidden_layer_evaluator_core.sv =====
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+--------------------------
// input    | i_operation i_hidden_index i_dim_index        | taken when start && !busy
//          | i_value i_final_coord                         |
// result   | o_kind o_index o_result_value o_last          | one cycle, o_result_valid
//
// Weight, bias and coordinate loads without final_coord leave busy low.
// An evaluation is paced by the serial divider and the single read port of each memory.
// Accept and reject sweep the stores with busy high.
// Reset is synchronous; the stores are not cleared. The receiver cannot stall.
module rbm_hidden_layer_evaluator_core #(
    parameter int HIDDEN_NODES = 16,
    parameter int DIMENSIONS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_hidden_index,
    input  logic [2:0]  i_dim_index,
    input  logic [31:0] i_value,
    input  logic        i_final_coord,
    output logic        o_result_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_index,
    output logic [31:0] o_result_value,
    output logic        o_last
);
    import rbmhe_pkg::*;

    localparam int HW   = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;
    localparam int DW   = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int WN   = HIDDEN_NODES * DIMENSIONS;
    localparam int WAW  = (WN > 1) ? $clog2(WN) : 1;
    localparam int MAXN = (HIDDEN_NODES > DIMENSIONS) ? HIDDEN_NODES : DIMENSIONS;
    localparam int IW   = (MAXN > 1) ? $clog2(MAXN) : 1;
    localparam logic [HW-1:0] H_LAST = HW'(HIDDEN_NODES - 1);
    localparam logic [DW-1:0] D_LAST = DW'(DIMENSIONS - 1);
    localparam logic [IW-1:0] I_LAST = IW'(MAXN - 1);

    // Sequencer states.
    localparam logic [5:0] S_IDLE    = 6'd0;
    localparam logic [5:0] S_CPY_RD  = 6'd1;
    localparam logic [5:0] S_CPY_WR  = 6'd2;
    localparam logic [5:0] S_RST_RD  = 6'd3;
    localparam logic [5:0] S_RST_WR  = 6'd4;
    localparam logic [5:0] S_B_RD    = 6'd5;
    localparam logic [5:0] S_B_LD    = 6'd6;
    localparam logic [5:0] S_V_RD    = 6'd7;
    localparam logic [5:0] S_V_MUL   = 6'd8;
    localparam logic [5:0] S_V_ACC   = 6'd9;
    localparam logic [5:0] S_V_SAT   = 6'd10;
    localparam logic [5:0] S_E_MUL   = 6'd11;
    localparam logic [5:0] S_E_INT   = 6'd12;
    localparam logic [5:0] S_E_FIN   = 6'd13;
    localparam logic [5:0] S_LG_DIV  = 6'd14;
    localparam logic [5:0] S_R_RD    = 6'd15;
    localparam logic [5:0] S_R_MUL   = 6'd16;
    localparam logic [5:0] S_R_NORM  = 6'd17;
    localparam logic [5:0] S_R_DGO   = 6'd18;
    localparam logic [5:0] S_R_DIV   = 6'd19;
    localparam logic [5:0] S_R_SQ    = 6'd20;
    localparam logic [5:0] S_R_SH    = 6'd21;
    localparam logic [5:0] S_G_INIT  = 6'd22;
    localparam logic [5:0] S_G_RD    = 6'd23;
    localparam logic [5:0] S_G_MUL   = 6'd24;
    localparam logic [5:0] S_G_ACC   = 6'd25;
    localparam logic [5:0] S_P_RDP   = 6'd26;
    localparam logic [5:0] S_P_PN    = 6'd27;
    localparam logic [5:0] S_P_RDW   = 6'd28;
    localparam logic [5:0] S_P_W2    = 6'd29;
    localparam logic [5:0] S_P_WP    = 6'd30;
    localparam logic [5:0] S_P_ACC   = 6'd31;
    localparam logic [5:0] S_RAT_OUT = 6'd32;

    // Memories and their registered read data.
    logic signed [31:0] mem_w  [WN];
    logic signed [31:0] mem_b  [HIDDEN_NODES];
    logic signed [31:0] mem_x  [DIMENSIONS];
    logic signed [31:0] mem_sx [DIMENSIONS];
    logic [31:0]        mem_p  [HIDDEN_NODES];
    logic [31:0]        mem_sp [HIDDEN_NODES];
    logic [31:0]        mem_n  [HIDDEN_NODES];
    logic signed [31:0] r_w_rd, r_b_rd, r_x_rd, r_sx_rd;
    logic [31:0]        r_p_rd, r_sp_rd, r_n_rd;

    // Control registers.
    logic [5:0]     r_state;
    logic [HW-1:0]  r_h;
    logic [DW-1:0]  r_d;
    logic [IW-1:0]  r_i;
    logic [WAW-1:0] r_wa;
    logic           r_init;
    logic           r_which;
    logic           r_act_init;
    logic [31:0]    r_ratio;
    logic [31:0]    r_sratio;
    logic           r_ovalid;
    logic [1:0]     r_kind;
    logic [3:0]     r_oidx;
    logic [31:0]    r_oval;
    logic           r_olast;

    // Datapath registers.
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic [31:0]        r_v;
    logic [31:0]        r_a;
    logic [48:0]        r_t;
    logic               r_ezero;
    logic [4:0]         r_k;
    logic [3:0]         r_idx;
    logic [28:0]        r_ip;
    logic [31:0]        r_m;
    logic signed [11:0] r_e;
    logic [31:0]        r_dm;
    logic signed [11:0] r_de;
    logic [31:0]        r_quo;
    logic [63:0]        r_sq;
    logic [17:0]        r_pn;
    logic [46:0]        r_w2;
    logic [47:0]        r_wp;
    logic [63:0]        r_lap;

    // Combinational signals.
    logic               acc_in;
    logic               hi_ok;
    logic               di_ok;
    logic               cp;
    logic               i_in_h;
    logic               i_in_d;
    logic [WAW-1:0]     ld_wa;
    logic               w_we, b_we, x_we, p_we, n_we, sp_we, sx_we;
    logic [DW-1:0]      x_wa, x_ra;
    logic [31:0]        x_wd;
    logic [HW-1:0]      p_wa, p_ra;
    logic [31:0]        p_wd;
    logic [31:0]        v_sat;
    logic [32:0]        t_q;
    logic [16:0]        e_m;
    logic [16:0]        e_val;
    logic               div_go;
    logic [63:0]        div_dvd;
    logic [31:0]        div_dvs;
    logic               div_done;
    logic [31:0]        div_q;
    logic [31:0]        big;
    logic [31:0]        small_v;
    logic [31:0]        n_val;
    logic [31:0]        p_val;
    logic [31:0]        r_x;
    logic               r_bad;
    logic [48:0]        r_mp;
    logic signed [13:0] sh_s;
    logic [63:0]        sq_sh;
    logic [31:0]        ratio_val;
    logic signed [63:0] g_next;
    logic signed [63:0] w_sq;
    logic [63:0]        lap_next;

    assign acc_in = start && !busy;
    assign hi_ok  = {3'b0, i_hidden_index} < 7'(HIDDEN_NODES);
    assign di_ok  = {3'b0, i_dim_index} < 6'(DIMENSIONS);
    assign ld_wa  = WAW'(WAW'(i_hidden_index) * WAW'(DIMENSIONS) + WAW'(i_dim_index));
    assign cp     = (r_state == S_CPY_RD) || (r_state == S_CPY_WR) ||
                    (r_state == S_RST_RD) || (r_state == S_RST_WR);
    assign i_in_h = {1'b0, r_i} < (IW + 1)'(HIDDEN_NODES);
    assign i_in_d = {1'b0, r_i} < (IW + 1)'(DIMENSIONS);

    // Write ports of the memories.
    always_comb begin
        w_we  = acc_in && (i_operation == OP_WEIGHT) && hi_ok && di_ok;
        b_we  = acc_in && (i_operation == OP_BIAS) && hi_ok;
        x_we  = 1'b0;
        x_wa  = DW'(i_dim_index);
        x_wd  = i_value;
        if (acc_in && ((i_operation == OP_INIT) || (i_operation == OP_PROP)) && di_ok) begin
            x_we = 1'b1;
        end else if ((r_state == S_RST_WR) && i_in_d) begin
            x_we = 1'b1;
            x_wa = r_i[DW-1:0];
            x_wd = r_sx_rd;
        end
        n_we  = (r_state == S_LG_DIV) && div_done;
        p_we  = n_we || ((r_state == S_RST_WR) && i_in_h);
        p_wa  = n_we ? r_h : r_i[HW-1:0];
        p_wd  = n_we ? p_val : r_sp_rd;
        sp_we = (r_state == S_CPY_WR) && i_in_h;
        sx_we = (r_state == S_CPY_WR) && i_in_d;
        x_ra  = cp ? r_i[DW-1:0] : r_d;
        p_ra  = cp ? r_i[HW-1:0] : r_h;
    end

    // Memory blocks: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_w[ld_wa] <= i_value;
        end
        r_w_rd <= mem_w[r_wa];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            mem_b[HW'(i_hidden_index)] <= i_value;
        end
        r_b_rd <= mem_b[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            mem_x[x_wa] <= x_wd;
        end
        r_x_rd <= mem_x[x_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sx_we) begin
            mem_sx[r_i[DW-1:0]] <= r_x_rd;
        end
        r_sx_rd <= mem_sx[r_i[DW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            mem_p[p_wa] <= p_wd;
        end
        r_p_rd <= mem_p[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            mem_sp[r_i[HW-1:0]] <= r_act_init ? r_p_rd : 32'd0;
        end
        r_sp_rd <= mem_sp[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem_n[r_h] <= n_val;
        end
        r_n_rd <= mem_n[r_h];
    end

    // Exponential approximation and logistic pair.
    always_comb begin
        v_sat   = sat32(r_acc);
        t_q     = r_t[48:16];
        e_m     = pow2_tab({1'b0, r_idx}) - 17'(r_ip >> 12);
        e_val   = r_ezero ? 17'd0 : (e_m >> r_k);
        big     = {15'd0, div_q[16:0]};
        small_v = ONE_Q - big;
        n_val   = r_v[31] ? small_v : big;
        p_val   = r_v[31] ? big : small_v;
    end

    // Shared divider operands.
    always_comb begin
        div_go  = (r_state == S_E_FIN) || (r_state == S_R_DGO);
        div_dvd = (r_state == S_R_DGO) ? {1'b0, r_m, 31'd0} : 64'h0000_0001_0000_0000;
        div_dvs = (r_state == S_R_DGO) ? r_dm : (ONE_Q + {15'd0, e_val});
    end

    rbmhe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Ratio, gradient and Laplacian helpers.
    always_comb begin
        r_x      = r_which ? r_sp_rd : r_p_rd;
        r_bad    = (r_x == 32'd0) || (r_x > ONE_Q);
        r_mp     = 49'(r_m) * 49'(r_x[16:0]);
        sh_s     = 14'sd46 - ((14'(r_e) - 14'(r_de)) <<< 1);
        sq_sh    = r_sq >> sh_s[5:0];
        if (sh_s >= 14'sd64) begin
            ratio_val = 32'd0;
        end else if (sh_s <= 14'sd0) begin
            ratio_val = SAT_MAXV;
        end else if (sq_sh > 64'(SAT_MAXV)) begin
            ratio_val = SAT_MAXV;
        end else begin
            ratio_val = sq_sh[31:0];
        end
        g_next   = r_acc + (r_prod >>> 16);
        w_sq     = r_w_rd * r_w_rd;
        lap_next = r_lap + 64'(r_wp);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_ratio    <= ONE_Q;
            r_sratio   <= ONE_Q;
            r_act_init <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        case (i_operation)
                            OP_ACCEPT: begin
                                r_sratio <= r_ratio;
                                r_i      <= '0;
                                r_state  <= S_CPY_RD;
                            end
                            OP_REJECT: begin
                                r_ratio <= r_sratio;
                                r_i     <= '0;
                                r_state <= S_RST_RD;
                            end
                            OP_INIT, OP_PROP: begin
                                if (i_final_coord) begin
                                    r_init  <= (i_operation == OP_INIT);
                                    r_h     <= '0;
                                    r_wa    <= '0;
                                    r_state <= S_B_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // Snapshot and restore sweeps.
                S_CPY_RD: r_state <= S_CPY_WR;
                S_CPY_WR: begin
                    if (r_i == I_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CPY_RD;
                    end
                end
                S_RST_RD: r_state <= S_RST_WR;
                S_RST_WR: begin
                    if (r_i == I_LAST) begin
                        r_act_init <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RST_RD;
                    end
                end
                // Visible-to-hidden sum for node r_h.
                S_B_RD: r_state <= S_B_LD;
                S_B_LD: begin
                    r_acc   <= {{32{r_b_rd[31]}}, r_b_rd};
                    r_d     <= '0;
                    r_state <= S_V_RD;
                end
                S_V_RD: r_state <= S_V_MUL;
                S_V_MUL: begin
                    r_prod  <= r_w_rd * r_x_rd;
                    r_state <= S_V_ACC;
                end
                S_V_ACC: begin
                    r_acc <= g_next;
                    r_wa  <= r_wa + 1'b1;
                    if (r_d == D_LAST) begin
                        r_state <= S_V_SAT;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_V_RD;
                    end
                end
                // e^-|v| by base-2 table interpolation.
                S_V_SAT: begin
                    r_v     <= v_sat;
                    r_a     <= v_sat[31] ? 32'(~v_sat + 32'd1) : v_sat;
                    r_state <= S_E_MUL;
                end
                S_E_MUL: begin
                    r_t     <= 49'(r_a) * 49'(LOG2E_Q);
                    r_state <= S_E_INT;
                end
                S_E_INT: begin
                    r_ezero <= |t_q[32:21];
                    r_k     <= t_q[20:16];
                    r_idx   <= t_q[15:12];
                    r_ip    <= 29'(pow2_tab({1'b0, t_q[15:12]})
                                   - pow2_tab(5'({1'b0, t_q[15:12]}) + 5'd1))
                               * 29'(t_q[11:0]);
                    r_state <= S_E_FIN;
                end
                S_E_FIN: r_state <= S_LG_DIV;
                S_LG_DIV: begin
                    if (div_done) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= KIND_ACT;
                        r_oidx   <= 4'(r_h);
                        r_oval   <= n_val;
                        r_olast  <= 1'b0;
                        if (r_h != H_LAST) begin
                            r_h     <= r_h + 1'b1;
                            r_state <= S_B_RD;
                        end else begin
                            r_act_init <= 1'b1;
                            if (r_init) begin
                                r_ratio <= ONE_Q;
                                r_state <= S_G_INIT;
                            end else begin
                                r_which <= 1'b0;
                                r_h     <= '0;
                                r_m     <= 32'h8000_0000;
                                r_e     <= -12'sd31;
                                r_state <= S_R_RD;
                            end
                        end
                    end
                end
                // Normalized products of new and saved probabilities.
                S_R_RD: r_state <= S_R_MUL;
                S_R_MUL: begin
                    if (r_bad) begin
                        r_ratio <= r_which ? 32'd0 : SAT_MAXV;
                        r_state <= S_G_INIT;
                    end else begin
                        r_m     <= r_mp[47:16];
                        r_state <= S_R_NORM;
                    end
                end
                S_R_NORM: begin
                    if (!r_m[31]) begin
                        r_m <= {r_m[30:0], 1'b0};
                        r_e <= r_e - 12'sd1;
                    end else if (r_h != H_LAST) begin
                        r_h     <= r_h + 1'b1;
                        r_state <= S_R_RD;
                    end else if (!r_which) begin
                        r_dm    <= r_m;
                        r_de    <= r_e;
                        r_which <= 1'b1;
                        r_h     <= '0;
                        r_m     <= 32'h8000_0000;
                        r_e     <= -12'sd31;
                        r_state <= S_R_RD;
                    end else begin
                        r_state <= S_R_DGO;
                    end
                end
                S_R_DGO: r_state <= S_R_DIV;
                S_R_DIV: begin
                    if (div_done) begin
                        r_quo   <= div_q;
                        r_state <= S_R_SQ;
                    end
                end
                S_R_SQ: begin
                    r_sq    <= 64'(r_quo) * 64'(r_quo);
                    r_state <= S_R_SH;
                end
                S_R_SH: begin
                    r_ratio <= ratio_val;
                    r_state <= S_G_INIT;
                end
                // Gradient: one dimension at a time over all nodes.
                S_G_INIT: begin
                    r_h     <= '0;
                    r_d     <= '0;
                    r_wa    <= '0;
                    r_acc   <= '0;
                    r_state <= S_G_RD;
                end
                S_G_RD: r_state <= S_G_MUL;
                S_G_MUL: begin
                    r_prod  <= r_w_rd * $signed(r_n_rd);
                    r_state <= S_G_ACC;
                end
                S_G_ACC: begin
                    if (r_h == H_LAST) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= KIND_GRAD;
                        r_oidx   <= 4'(r_d);
                        r_oval   <= sat32(g_next);
                        r_olast  <= 1'b0;
                        r_h      <= '0;
                        if (r_d == D_LAST) begin
                            r_d     <= '0;
                            r_wa    <= '0;
                            r_lap   <= '0;
                            r_state <= S_P_RDP;
                        end else begin
                            r_d     <= r_d + 1'b1;
                            r_wa    <= WAW'(r_d) + 1'b1;
                            r_acc   <= '0;
                            r_state <= S_G_RD;
                        end
                    end else begin
                        r_acc   <= g_next;
                        r_h     <= r_h + 1'b1;
                        r_wa    <= r_wa + WAW'(DIMENSIONS);
                        r_state <= S_G_RD;
                    end
                end
                // Laplacian: unsigned sum of W^2 * p * n.
                S_P_RDP: r_state <= S_P_PN;
                S_P_PN: begin
                    r_pn    <= 18'((34'(r_p_rd[16:0]) * 34'(r_n_rd[16:0])) >> 16);
                    r_state <= S_P_RDW;
                end
                S_P_RDW: r_state <= S_P_W2;
                S_P_W2: begin
                    r_w2    <= 47'(64'(w_sq) >> 16);
                    r_state <= S_P_WP;
                end
                S_P_WP: begin
                    r_wp    <= 48'((65'(r_w2) * 65'(r_pn)) >> 16);
                    r_state <= S_P_ACC;
                end
                S_P_ACC: begin
                    r_lap <= lap_next;
                    r_wa  <= r_wa + 1'b1;
                    if (r_d == D_LAST) begin
                        r_d <= '0;
                        if (r_h == H_LAST) begin
                            r_ovalid <= 1'b1;
                            r_kind   <= KIND_LAP;
                            r_oidx   <= 4'd0;
                            r_oval   <= (lap_next > 64'(SAT_MAXV)) ? SAT_MAXV
                                                                   : lap_next[31:0];
                            r_olast  <= 1'b0;
                            r_state  <= S_RAT_OUT;
                        end else begin
                            r_h     <= r_h + 1'b1;
                            r_state <= S_P_RDP;
                        end
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_P_RDW;
                    end
                end
                S_RAT_OUT: begin
                    r_ovalid <= 1'b1;
                    r_kind   <= KIND_RATIO;
                    r_oidx   <= 4'd0;
                    r_oval   <= r_ratio;
                    r_olast  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_ovalid;
    assign o_kind         = r_kind;
    assign o_index        = r_oidx;
    assign o_result_value = r_oval;
    assign o_last         = r_olast;
endmodule

// ===== src/rbmhe_chk.sv =====
module rbmhe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] i_operation,
    input logic       i_final_coord,
    input logic       o_result_valid,
    input logic [1:0] o_kind,
    input logic       o_last
);
    import rbmhe_pkg::*;

    // Only the ratio beat closes a run.
    a_last_is_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_kind == KIND_RATIO) == o_last))
        else $error("last flag and ratio kind disagree");

    // A final coordinate beat starts an evaluation.
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_final_coord &&
         (i_operation == OP_INIT || i_operation == OP_PROP)) |=> busy)
        else $error("evaluation did not start");

    // Weight and bias loads complete in their own cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_WEIGHT || i_operation == OP_BIAS))
        |=> !busy)
        else $error("load held the block busy");

    // Nothing follows the final beat of a run right away.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last) |=> !o_result_valid)
        else $error("result beat right after the last beat");
endmodule

bind rbm_hidden_layer_evaluator_core rbmhe_chk u_rbmhe_chk (.*);

// ===== bench/testbench.sv =====
module testbench;
    import rbmhe_pkg::*;

    localparam int HID = 16;
    localparam int DIM = 8;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    // Operation codes that the block does not define.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int unsigned EXP2_FRAC[17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  hid;
        logic [2:0]  dim;
        logic [31:0] val;
        logic        fin;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  index;
        logic [31:0] value;
        logic        last;
    } res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_operation = OP_WEIGHT;
    logic [3:0]  i_hidden_index = '0;
    logic [2:0]  i_dim_index = '0;
    logic [31:0] i_value = '0;
    logic        i_final_coord = 1'b0;
    logic        o_result_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_index;
    logic [31:0] o_result_value;
    logic        o_last;

    rbm_hidden_layer_evaluator_core #(
        .HIDDEN_NODES(HID),
        .DIMENSIONS(DIM)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_hidden_index(i_hidden_index),
        .i_dim_index(i_dim_index),
        .i_value(i_value),
        .i_final_coord(i_final_coord),
        .o_result_valid(o_result_valid),
        .o_kind(o_kind),
        .o_index(o_index),
        .o_result_value(o_result_value),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's stores.
    int w_mem[HID*DIM];
    int b_mem[HID];
    int x_mem[DIM];
    int p_act[HID];
    int n_act[HID];
    int p_kept[HID];
    int n_kept[HID];
    int x_kept[DIM];
    int ratio_now = 65536;
    int ratio_kept = 65536;

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int   cmds_taken = 0;
    int   evals_seen = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;

    function automatic longint floor_mul(int a, int b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> 16;
    endfunction

    function automatic int clip32(longint a);
        if (a > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (a < -64'sd2147483648) return 32'h8000_0000;
        return int'(a);
    endfunction

    // e^-a in Q16.16 through a base-2 table with linear interpolation.
    function automatic longint unsigned exp_decay(longint unsigned a);
        longint unsigned t, k, f, idx, fr, m;
        t = (a * 64'd94548) >> 16;
        k = t >> 16;
        f = t & 64'hFFFF;
        idx = f >> 12;
        fr = f & 64'hFFF;
        if (k >= 32) return 0;
        m = EXP2_FRAC[idx] - (((EXP2_FRAC[idx] - EXP2_FRAC[idx+1]) * fr) >> 12);
        return m >> k;
    endfunction

    // Product of probabilities as a normalized mantissa and exponent.
    function automatic bit prob_product(input int arr[HID], output longint unsigned mant,
                                        output int ex);
        longint unsigned m, x;
        int e;
        m = 64'h8000_0000;
        e = -31;
        mant = 0;
        ex = 0;
        for (int i = 0; i < HID; i++) begin
            x = longint'(unsigned'(arr[i]));
            if (x == 0 || x > 65536) return 1'b0;
            m = (m * x) >> 16;
            while ((m & 64'h8000_0000) == 0) begin
                m = m << 1;
                e--;
            end
        end
        mant = m;
        ex = e;
        return 1'b1;
    endfunction

    function automatic int move_ratio();
        longint unsigned nm, dm, q, sq;
        int ne, de, s;
        if (!prob_product(p_act, dm, de)) return 32'h7FFF_FFFF;
        if (!prob_product(p_kept, nm, ne)) return 0;
        q = (nm << 31) / dm;
        sq = q * q;
        s = 46 - 2 * (ne - de);
        if (s >= 64) return 0;
        if (s <= 0) return 32'h7FFF_FFFF;
        sq = sq >> s;
        if (sq > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return int'(sq);
    endfunction

    function automatic void push_result(logic [1:0] kind, int idx, int value, bit last);
        res_t r;
        r.kind = kind;
        r.index = idx[3:0];
        r.value = value;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    // Full evaluation of the hidden layer at the current coordinates.
    task automatic evaluate_layer(bit initial_place);
        longint acc, g;
        longint unsigned e, big, lap, pn, w2, wl;
        int v;
        lap = 0;
        for (int h = 0; h < HID; h++) begin
            acc = b_mem[h];
            for (int d = 0; d < DIM; d++) acc += floor_mul(w_mem[h*DIM+d], x_mem[d]);
            v = clip32(acc);
            e = exp_decay(v < 0 ? longint'(-longint'(v)) : longint'(v));
            big = 64'h1_0000_0000 / (65536 + e);
            n_act[h] = v >= 0 ? int'(big) : int'(65536 - big);
            p_act[h] = v >= 0 ? int'(65536 - big) : int'(big);
        end
        ratio_now = initial_place ? 65536 : move_ratio();
        for (int h = 0; h < HID; h++) push_result(KIND_ACT, h, n_act[h], 1'b0);
        for (int d = 0; d < DIM; d++) begin
            g = 0;
            for (int h = 0; h < HID; h++) g += floor_mul(w_mem[h*DIM+d], n_act[h]);
            push_result(KIND_GRAD, d, clip32(g), 1'b0);
        end
        for (int h = 0; h < HID; h++) begin
            pn = (longint'(p_act[h]) * longint'(n_act[h])) >> 16;
            for (int d = 0; d < DIM; d++) begin
                wl = longint'(w_mem[h*DIM+d]) * longint'(w_mem[h*DIM+d]);
                w2 = wl >> 16;
                lap += (w2 * pn) >> 16;
            end
        end
        push_result(KIND_LAP, 0, lap > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : int'(lap), 1'b0);
        push_result(KIND_RATIO, 0, ratio_now, 1'b1);
        evals_seen++;
    endtask

    task automatic apply_command(cmd_t c);
        case (c.op)
            OP_WEIGHT: w_mem[c.hid*DIM + c.dim] = c.val;
            OP_BIAS:   b_mem[c.hid] = c.val;
            OP_INIT, OP_PROP: begin
                x_mem[c.dim] = c.val;
                if (c.fin) evaluate_layer(c.op == OP_INIT);
            end
            OP_ACCEPT: begin
                x_kept = x_mem;
                p_kept = p_act;
                n_kept = n_act;
                ratio_kept = ratio_now;
            end
            OP_REJECT: begin
                x_mem = x_kept;
                p_act = p_kept;
                n_act = n_kept;
                ratio_now = ratio_kept;
            end
            default: ;
        endcase
    endtask

    // Mostly modest values near the working range, with extremes and raw words mixed in.
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return $urandom_range(0, 393216) - 196608;
        if (sel < 90) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 0;
        if (sel < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_cmd(logic [2:0] op, int hid, int dim, logic [31:0] val,
                                      bit fin);
        cmd_t c;
        c.op = op;
        c.hid = hid[3:0];
        c.dim = dim[2:0];
        c.val = val;
        c.fin = fin;
        pending_cmds.push_back(c);
    endfunction

    // Driver: presents the next beat once the current one is taken.
    always @(posedge i_clk) begin
        cmd_t c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_command({i_operation, i_hidden_index, i_dim_index, i_value,
                               i_final_coord});
                cmds_taken++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    i_operation <= c.op;
                    i_hidden_index <= c.hid;
                    i_dim_index <= c.dim;
                    i_value <= c.val;
                    i_final_coord <= c.fin;
                    start <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result beat against the oldest expectation, plus a stall watchdog.
    always @(posedge i_clk) begin
        res_t want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: kind %0d index %0d value %h last %0d",
                                 o_kind, o_index, o_result_value, o_last);
                end else begin
                    want = expected_results.pop_front();
                    if (o_kind !== want.kind || o_index !== want.index ||
                        o_result_value !== want.value || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected kind %0d index %0d value %h last %0d, got kind %0d index %0d value %h last %0d",
                                     want.kind, want.index, want.value, want.last,
                                     o_kind, o_index, o_result_value, o_last);
                    end
                end
            end
            if (o_result_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rbm_hidden_layer_evaluator_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int sel, op_pick;
        bit fin;

        // Every weight and bias first, so no evaluation reads an unwritten entry.
        for (int h = 0; h < HID; h++)
            for (int d = 0; d < DIM; d++)
                queue_cmd(OP_WEIGHT, h, d, $urandom_range(0, 131072) - 65536, 1'b0);
        for (int h = 0; h < HID; h++)
            queue_cmd(OP_BIAS, h, 0, $urandom_range(0, 131072) - 65536, 1'b0);

        // Directed part: placement, accept, proposal, reject and saturating cases.
        for (int d = 0; d < DIM; d++)
            queue_cmd(OP_INIT, 0, d, $urandom_range(0, 131072) - 65536, d == DIM - 1);
        queue_cmd(OP_ACCEPT, 0, 0, 0, 1'b0);
        queue_cmd(OP_PROP, 0, 3, 32'h0000_8000, 1'b1);
        queue_cmd(OP_REJECT, 0, 0, 0, 1'b0);
        // A huge activation drives a probability to zero in the denominator.
        queue_cmd(OP_BIAS, 0, 0, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(OP_PROP, 0, 0, 32'h0001_0000, 1'b1);
        queue_cmd(OP_ACCEPT, 0, 0, 0, 1'b1);
        // Now the kept product holds a zero, so the next ratio is zero.
        queue_cmd(OP_BIAS, 0, 0, 32'h0000_4000, 1'b0);
        queue_cmd(OP_PROP, 0, 0, 32'hFFFF_0000, 1'b1);
        queue_cmd(OP_ACCEPT, 0, 0, 0, 1'b0);
        queue_cmd(OP_BIAS, 1, 0, 32'h8000_0000, 1'b0);
        queue_cmd(OP_WEIGHT, 15, 7, 32'h8000_0000, 1'b1);
        queue_cmd(OP_PROP, 0, 7, 32'h7FFF_FFFF, 1'b1);
        queue_cmd(OP_SPARE_6, 15, 7, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(OP_SPARE_7, 0, 0, 32'h0000_0000, 1'b1);
        queue_cmd(OP_REJECT, 0, 0, 0, 1'b1);
        queue_cmd(OP_BIAS, 1, 0, 32'h0000_2000, 1'b0);
        queue_cmd(OP_WEIGHT, 15, 7, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(OP_WEIGHT, 15, 7, 32'h0000_1000, 1'b0);
        queue_cmd(OP_INIT, 0, 2, 32'h0000_C000, 1'b0);
        queue_cmd(OP_INIT, 0, 5, 32'hFFFF_4000, 1'b1);
        queue_cmd(OP_ACCEPT, 0, 0, 0, 1'b0);

        // Random part: mostly coordinate moves with accept or reject, loads and noise between.
        for (int i = 0; i < 130; i++) begin
            sel = $urandom_range(0, 99);
            fin = $urandom_range(0, 2) == 0;
            if (sel < 40) begin
                op_pick = $urandom_range(0, 4) == 0 ? OP_INIT : OP_PROP;
                queue_cmd(op_pick[2:0], $urandom_range(0, 15), $urandom_range(0, 7),
                          pick_value(), fin);
            end else if (sel < 55) begin
                queue_cmd(OP_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 7),
                          pick_value(), fin);
            end else if (sel < 62) begin
                queue_cmd(OP_BIAS, $urandom_range(0, 15), $urandom_range(0, 7),
                          pick_value(), fin);
            end else if (sel < 76) begin
                queue_cmd(OP_ACCEPT, $urandom_range(0, 15), $urandom_range(0, 7),
                          $urandom, fin);
            end else if (sel < 90) begin
                queue_cmd(OP_REJECT, $urandom_range(0, 15), $urandom_range(0, 7),
                          $urandom, fin);
            end else begin
                op_pick = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
                queue_cmd(op_pick[2:0], $urandom_range(0, 15), $urandom_range(0, 7),
                          $urandom, fin);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all beats taken and every expected result seen.
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Took %0d command beats, ran %0d layer evaluations, checked %0d result beats.",
                 cmds_taken, evals_seen, results_checked);
        $display("Mismatches seen: %0d.", mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("rbm_hidden_layer_evaluator_core regression: pass");
        end else begin
            $display("rbm_hidden_layer_evaluator_core regression: fail");
        end
        $finish;
    end
endmodule
